// ===== hdl/rsnp_pkg.sv =====
`default_nettype none
// ============================================================================
// rsnp_pkg
// Shared types and constants of the nearest ray-sphere pick block.
// ============================================================================
package rsnp_pkg;

    localparam int COORD_W = 24;          // Q12.12 coordinate width
    localparam int RADIUS_W = 23;         // unsigned Q11.12 radius width
    localparam int DIFF_W = COORD_W + 1;  // origin minus centre
    localparam int MUL_W = 27;            // signed multiplier operand width
    localparam int PROD_W = 2 * MUL_W;    // signed product width
    localparam int DOT_W = 52;            // dot products and squares
    localparam int HALF_W = 25;           // split point of wide operands
    localparam int MAG_W = 50;            // magnitude of |h| and c
    localparam int WIDE_W = 100;          // h*h, a*c and discriminant
    localparam int ROOT_W = 50;           // floor square root width
    localparam int REM_W = 54;            // square root remainder width
    localparam int NUM_W = 56;            // root numerator width
    localparam int INDEX_W = 10;          // result index width

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_RADIUS = 3'd0;
    localparam logic [2:0] REG_ORIGIN_X = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd3;
    localparam logic [2:0] REG_DIR_X = 3'd4;
    localparam logic [2:0] REG_DIR_Y = 3'd5;
    localparam logic [2:0] REG_DIR_Z = 3'd6;

    typedef struct packed {
        logic [RADIUS_W-1:0]       radius;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } cfg_t;

    // One queued request between the front and the back.
    typedef struct packed {
        logic signed [DIFF_W-1:0] ox;
        logic signed [DIFF_W-1:0] oy;
        logic signed [DIFF_W-1:0] oz;
        logic                     last;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CLASSIFY,
        ST_DISC,
        ST_SQRT,
        ST_ROOT,
        ST_PICK,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

// ===== hdl/ray_sphere_nearest_pick.sv =====
`default_nettype none
// ============================================================================
// ray_sphere_nearest_pick
// Picks the nearest sphere hit by a configured ray from a stream of centres.
// ============================================================================
// Sphere centres arrive as requests on the s_ channel (x, y, z in s_tdata,
// s_tlast on the final centre of a pick query). One result request leaves on
// the m_ channel for each query: m_tuser carries the found flag and m_tdata
// the list position of the nearest hit sphere (zero when nothing was hit).
// The ray origin, ray direction and common radius are APB registers; the
// user writes them only while the block is idle, which it does not enforce.
// The front subtracts each centre from the origin and places it in a
// two-entry queue, so up to two centres are taken while the back is busy.
// The back runs up to seventeen multiply steps on one shared 27x27 multiplier,
// each a multiply state then an accumulate state, then a square root that
// retires one result bit per cycle. A centre rejected by the origin or
// zero-direction test or with a negative discriminant skips to the compare
// step early, and a centre past MAX_POINTS goes there at once. The result
// register loads in the emit state that follows the last centre's compare
// step, once the output is free. Reset clears the query state and loads the
// default ray and radius. When the receiver stalls, the result waits in its
// register and the back holds at the end of the next query until it is taken.
// ============================================================================
module ray_sphere_nearest_pick
#(
    parameter int MAX_POINTS = 1024
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [71:0]  s_tdata,     // center_x[23:0], center_y[47:24], center_z[71:48]
    input  wire         s_tlast,     // last_point
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,     // nearest_index[9:0], zero fill [15:10]
    output logic        m_tuser,     // found
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [4:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rsnp_pkg::cfg_t   cfg_reg;
    rsnp_pkg::entry_t q_data;
    logic             q_valid;
    logic             q_ready;
    logic             cfg_write;
    logic [rsnp_pkg::INDEX_W-1:0] out_index;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers; unused upper data bits are dropped on write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius <= 23'd4506;
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.origin_z <= '0;
            cfg_reg.dir_x <= '0;
            cfg_reg.dir_y <= '0;
            cfg_reg.dir_z <= 24'sd4096;
        end
        else if (cfg_write && (paddr[1:0] == 2'b00))
        begin
            unique case (paddr[4:2])
                rsnp_pkg::REG_RADIUS:   cfg_reg.radius <= pwdata[rsnp_pkg::RADIUS_W-1:0];
                rsnp_pkg::REG_ORIGIN_X: cfg_reg.origin_x <= pwdata[rsnp_pkg::COORD_W-1:0];
                rsnp_pkg::REG_ORIGIN_Y: cfg_reg.origin_y <= pwdata[rsnp_pkg::COORD_W-1:0];
                rsnp_pkg::REG_ORIGIN_Z: cfg_reg.origin_z <= pwdata[rsnp_pkg::COORD_W-1:0];
                rsnp_pkg::REG_DIR_X:    cfg_reg.dir_x <= pwdata[rsnp_pkg::COORD_W-1:0];
                rsnp_pkg::REG_DIR_Y:    cfg_reg.dir_y <= pwdata[rsnp_pkg::COORD_W-1:0];
                rsnp_pkg::REG_DIR_Z:    cfg_reg.dir_z <= pwdata[rsnp_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data returns the raw register bits, zero filled.
    always_comb
    begin
        unique case (paddr[4:2])
            rsnp_pkg::REG_RADIUS:   prdata = 32'(cfg_reg.radius);
            rsnp_pkg::REG_ORIGIN_X: prdata = 32'(unsigned'(cfg_reg.origin_x));
            rsnp_pkg::REG_ORIGIN_Y: prdata = 32'(unsigned'(cfg_reg.origin_y));
            rsnp_pkg::REG_ORIGIN_Z: prdata = 32'(unsigned'(cfg_reg.origin_z));
            rsnp_pkg::REG_DIR_X:    prdata = 32'(unsigned'(cfg_reg.dir_x));
            rsnp_pkg::REG_DIR_Y:    prdata = 32'(unsigned'(cfg_reg.dir_y));
            rsnp_pkg::REG_DIR_Z:    prdata = 32'(unsigned'(cfg_reg.dir_z));
            default:                prdata = '0;
        endcase
    end

    rsnp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    rsnp_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_found (m_tuser),
        .out_index (out_index)
    );

    assign m_tdata = {6'b0, out_index};

endmodule
`default_nettype wire

// ===== hdl/rsnp_front.sv =====
`default_nettype none
// ============================================================================
// rsnp_front
// Accepts sphere centres, forms origin minus centre and queues the requests.
// ============================================================================
module rsnp_front
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire rsnp_pkg::cfg_t                cfg,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [3*rsnp_pkg::COORD_W-1:0]      s_tdata,
    input  wire                                s_tlast,
    output logic                               q_valid,
    input  wire                                q_ready,
    output rsnp_pkg::entry_t                   q_data
);

    rsnp_pkg::entry_t queue_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    rsnp_pkg::entry_t entry_in;

    logic signed [rsnp_pkg::COORD_W-1:0] cx, cy, cz;

    assign cx = s_tdata[rsnp_pkg::COORD_W-1:0];
    assign cy = s_tdata[2*rsnp_pkg::COORD_W-1:rsnp_pkg::COORD_W];
    assign cz = s_tdata[3*rsnp_pkg::COORD_W-1:2*rsnp_pkg::COORD_W];

    always_comb
    begin
        entry_in.ox = rsnp_pkg::DIFF_W'(cfg.origin_x) - rsnp_pkg::DIFF_W'(cx);
        entry_in.oy = rsnp_pkg::DIFF_W'(cfg.origin_y) - rsnp_pkg::DIFF_W'(cy);
        entry_in.oz = rsnp_pkg::DIFF_W'(cfg.origin_z) - rsnp_pkg::DIFF_W'(cz);
        entry_in.last = s_tlast;
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data = queue_reg[rd_ptr_reg];
    assign push = s_tvalid && s_tready;
    assign pop = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/rsnp_back.sv =====
`default_nettype none
// ============================================================================
// rsnp_back
// Solves the ray-sphere quadratic with one shared multiplier and a
// bit-pair square root, keeps the nearest hit and delivers the result.
// ============================================================================
module rsnp_back
#(
    parameter int MAX_POINTS = 1024
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire rsnp_pkg::cfg_t                cfg,
    input  wire                                q_valid,
    output logic                               q_ready,
    input  wire rsnp_pkg::entry_t              q_data,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic                               out_found,
    output logic [rsnp_pkg::INDEX_W-1:0]       out_index
);

    localparam int POS_W = $clog2(MAX_POINTS + 1);
    localparam int SQRT_STEPS = rsnp_pkg::ROOT_W;
    localparam int CNT_W = $clog2(SQRT_STEPS);

    // Multiplier steps in the order they run.
    localparam logic [4:0] STEP_OXX = 5'd0;
    localparam logic [4:0] STEP_OYY = 5'd1;
    localparam logic [4:0] STEP_OZZ = 5'd2;
    localparam logic [4:0] STEP_RR = 5'd3;
    localparam logic [4:0] STEP_DXX = 5'd4;
    localparam logic [4:0] STEP_DYY = 5'd5;
    localparam logic [4:0] STEP_DZZ = 5'd6;
    localparam logic [4:0] STEP_OXD = 5'd7;
    localparam logic [4:0] STEP_OYD = 5'd8;
    localparam logic [4:0] STEP_OZD = 5'd9;
    localparam logic [4:0] STEP_HLL = 5'd10;
    localparam logic [4:0] STEP_HLH = 5'd11;
    localparam logic [4:0] STEP_HHH = 5'd12;
    localparam logic [4:0] STEP_ALL = 5'd13;
    localparam logic [4:0] STEP_ALH = 5'd14;
    localparam logic [4:0] STEP_AHL = 5'd15;
    localparam logic [4:0] STEP_AHH = 5'd16;

    rsnp_pkg::state_t state_reg, state_next;

    logic [4:0]                               step_reg;
    rsnp_pkg::entry_t                         item_reg;
    logic                                     in_range_reg;
    logic                                     hit_reg;
    logic signed [rsnp_pkg::PROD_W-1:0]       prod_reg;
    logic signed [rsnp_pkg::DOT_W-1:0]        oo_reg, r2_reg, a_reg, h_reg;
    logic [rsnp_pkg::MAG_W-1:0]               c_reg, hm_reg;
    logic [rsnp_pkg::WIDE_W-1:0]              bb_reg, ac_reg, rad_reg;
    logic [rsnp_pkg::REM_W-1:0]               rem_reg;
    logic [rsnp_pkg::ROOT_W-1:0]              root_reg;
    logic [CNT_W-1:0]                         cnt_reg;
    logic signed [rsnp_pkg::NUM_W-1:0]        num_reg, best_num_reg;
    logic                                     best_valid_reg;
    logic [POS_W-1:0]                         pos_reg, best_pos_reg;
    logic                                     out_valid_reg;
    logic                                     out_found_reg;
    logic [rsnp_pkg::INDEX_W-1:0]             out_index_reg;

    logic signed [rsnp_pkg::MUL_W-1:0]        mul_a, mul_b;
    logic                                     item_in_range;
    logic                                     no_hit_early;
    logic                                     out_free;
    logic [rsnp_pkg::REM_W-1:0]               rem_shift, trial;
    logic                                     take_bit;
    logic signed [rsnp_pkg::NUM_W-1:0]        neg_h, s_ext, near_num;

    assign item_in_range = (pos_reg < POS_W'(MAX_POINTS));
    assign no_hit_early = (oo_reg <= r2_reg) || (a_reg == '0);
    assign out_free = !out_valid_reg || out_ready;

    // One pair of radicand bits per cycle.
    assign rem_shift = {rem_reg[rsnp_pkg::REM_W-3:0],
                        rad_reg[rsnp_pkg::WIDE_W-1:rsnp_pkg::WIDE_W-2]};
    assign trial = rsnp_pkg::REM_W'({root_reg, 2'b01});
    assign take_bit = (rem_shift >= trial);

    assign neg_h = -rsnp_pkg::NUM_W'(h_reg);
    assign s_ext = rsnp_pkg::NUM_W'($signed({1'b0, root_reg}));
    assign near_num = neg_h - s_ext;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsnp_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = item_in_range ? rsnp_pkg::ST_MUL : rsnp_pkg::ST_PICK;
                end
            end
            rsnp_pkg::ST_MUL:
            begin
                state_next = rsnp_pkg::ST_ACC;
            end
            rsnp_pkg::ST_ACC:
            begin
                if (step_reg == STEP_OZD)
                begin
                    state_next = rsnp_pkg::ST_CLASSIFY;
                end
                else if (step_reg == STEP_AHH)
                begin
                    state_next = rsnp_pkg::ST_DISC;
                end
                else
                begin
                    state_next = rsnp_pkg::ST_MUL;
                end
            end
            rsnp_pkg::ST_CLASSIFY:
            begin
                state_next = no_hit_early ? rsnp_pkg::ST_PICK : rsnp_pkg::ST_MUL;
            end
            rsnp_pkg::ST_DISC:
            begin
                state_next = (ac_reg > bb_reg) ? rsnp_pkg::ST_PICK : rsnp_pkg::ST_SQRT;
            end
            rsnp_pkg::ST_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = rsnp_pkg::ST_ROOT;
                end
            end
            rsnp_pkg::ST_ROOT:
            begin
                state_next = rsnp_pkg::ST_PICK;
            end
            rsnp_pkg::ST_PICK:
            begin
                state_next = item_reg.last ? rsnp_pkg::ST_EMIT : rsnp_pkg::ST_IDLE;
            end
            rsnp_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = rsnp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsnp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: queue pop and multiplier operand selection.
    always_comb
    begin
        q_ready = (state_reg == rsnp_pkg::ST_IDLE);
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            STEP_OXX:
            begin
                mul_a = rsnp_pkg::MUL_W'(item_reg.ox);
                mul_b = rsnp_pkg::MUL_W'(item_reg.ox);
            end
            STEP_OYY:
            begin
                mul_a = rsnp_pkg::MUL_W'(item_reg.oy);
                mul_b = rsnp_pkg::MUL_W'(item_reg.oy);
            end
            STEP_OZZ:
            begin
                mul_a = rsnp_pkg::MUL_W'(item_reg.oz);
                mul_b = rsnp_pkg::MUL_W'(item_reg.oz);
            end
            STEP_RR:
            begin
                mul_a = $signed({4'b0, cfg.radius});
                mul_b = $signed({4'b0, cfg.radius});
            end
            STEP_DXX:
            begin
                mul_a = rsnp_pkg::MUL_W'(cfg.dir_x);
                mul_b = rsnp_pkg::MUL_W'(cfg.dir_x);
            end
            STEP_DYY:
            begin
                mul_a = rsnp_pkg::MUL_W'(cfg.dir_y);
                mul_b = rsnp_pkg::MUL_W'(cfg.dir_y);
            end
            STEP_DZZ:
            begin
                mul_a = rsnp_pkg::MUL_W'(cfg.dir_z);
                mul_b = rsnp_pkg::MUL_W'(cfg.dir_z);
            end
            STEP_OXD:
            begin
                mul_a = rsnp_pkg::MUL_W'(item_reg.ox);
                mul_b = rsnp_pkg::MUL_W'(cfg.dir_x);
            end
            STEP_OYD:
            begin
                mul_a = rsnp_pkg::MUL_W'(item_reg.oy);
                mul_b = rsnp_pkg::MUL_W'(cfg.dir_y);
            end
            STEP_OZD:
            begin
                mul_a = rsnp_pkg::MUL_W'(item_reg.oz);
                mul_b = rsnp_pkg::MUL_W'(cfg.dir_z);
            end
            STEP_HLL:
            begin
                mul_a = $signed({2'b0, hm_reg[rsnp_pkg::HALF_W-1:0]});
                mul_b = $signed({2'b0, hm_reg[rsnp_pkg::HALF_W-1:0]});
            end
            STEP_HLH:
            begin
                mul_a = $signed({2'b0, hm_reg[rsnp_pkg::HALF_W-1:0]});
                mul_b = $signed({2'b0, hm_reg[rsnp_pkg::MAG_W-1:rsnp_pkg::HALF_W]});
            end
            STEP_HHH:
            begin
                mul_a = $signed({2'b0, hm_reg[rsnp_pkg::MAG_W-1:rsnp_pkg::HALF_W]});
                mul_b = $signed({2'b0, hm_reg[rsnp_pkg::MAG_W-1:rsnp_pkg::HALF_W]});
            end
            STEP_ALL:
            begin
                mul_a = $signed({2'b0, a_reg[rsnp_pkg::HALF_W-1:0]});
                mul_b = $signed({2'b0, c_reg[rsnp_pkg::HALF_W-1:0]});
            end
            STEP_ALH:
            begin
                mul_a = $signed({2'b0, a_reg[rsnp_pkg::HALF_W-1:0]});
                mul_b = $signed({2'b0, c_reg[rsnp_pkg::MAG_W-1:rsnp_pkg::HALF_W]});
            end
            STEP_AHL:
            begin
                mul_a = $signed({2'b0, a_reg[rsnp_pkg::MAG_W-1:rsnp_pkg::HALF_W]});
                mul_b = $signed({2'b0, c_reg[rsnp_pkg::HALF_W-1:0]});
            end
            STEP_AHH:
            begin
                mul_a = $signed({2'b0, a_reg[rsnp_pkg::MAG_W-1:rsnp_pkg::HALF_W]});
                mul_b = $signed({2'b0, c_reg[rsnp_pkg::MAG_W-1:rsnp_pkg::HALF_W]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsnp_pkg::ST_IDLE;
            best_valid_reg <= 1'b0;
            best_pos_reg <= '0;
            best_num_reg <= '0;
            pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == rsnp_pkg::ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == rsnp_pkg::ST_PICK)
            begin
                if (in_range_reg)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if (hit_reg && (!best_valid_reg || (num_reg < best_num_reg)))
                begin
                    best_valid_reg <= 1'b1;
                    best_num_reg <= num_reg;
                    best_pos_reg <= pos_reg;
                end
            end
            if ((state_reg == rsnp_pkg::ST_EMIT) && out_free)
            begin
                best_valid_reg <= 1'b0;
                best_num_reg <= '0;
                best_pos_reg <= '0;
                pos_reg <= '0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rsnp_pkg::ST_IDLE:
            begin
                item_reg <= q_data;
                in_range_reg <= item_in_range;
                hit_reg <= 1'b0;
                step_reg <= STEP_OXX;
            end
            rsnp_pkg::ST_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            rsnp_pkg::ST_ACC:
            begin
                step_reg <= step_reg + 5'd1;
                case (step_reg)
                    STEP_OXX: oo_reg <= prod_reg[rsnp_pkg::DOT_W-1:0];
                    STEP_OYY: oo_reg <= oo_reg + prod_reg[rsnp_pkg::DOT_W-1:0];
                    STEP_OZZ: oo_reg <= oo_reg + prod_reg[rsnp_pkg::DOT_W-1:0];
                    STEP_RR:  r2_reg <= prod_reg[rsnp_pkg::DOT_W-1:0];
                    STEP_DXX: a_reg <= prod_reg[rsnp_pkg::DOT_W-1:0];
                    STEP_DYY: a_reg <= a_reg + prod_reg[rsnp_pkg::DOT_W-1:0];
                    STEP_DZZ: a_reg <= a_reg + prod_reg[rsnp_pkg::DOT_W-1:0];
                    STEP_OXD: h_reg <= prod_reg[rsnp_pkg::DOT_W-1:0];
                    STEP_OYD: h_reg <= h_reg + prod_reg[rsnp_pkg::DOT_W-1:0];
                    STEP_OZD: h_reg <= h_reg + prod_reg[rsnp_pkg::DOT_W-1:0];
                    STEP_HLL: bb_reg <= rsnp_pkg::WIDE_W'(prod_reg[rsnp_pkg::DOT_W-1:0]);
                    STEP_HLH: bb_reg <= bb_reg
                        + (rsnp_pkg::WIDE_W'(prod_reg[rsnp_pkg::DOT_W-1:0])
                           << (rsnp_pkg::HALF_W + 1));
                    STEP_HHH: bb_reg <= bb_reg
                        + (rsnp_pkg::WIDE_W'(prod_reg[rsnp_pkg::DOT_W-1:0])
                           << (2 * rsnp_pkg::HALF_W));
                    STEP_ALL: ac_reg <= rsnp_pkg::WIDE_W'(prod_reg[rsnp_pkg::DOT_W-1:0]);
                    STEP_ALH, STEP_AHL: ac_reg <= ac_reg
                        + (rsnp_pkg::WIDE_W'(prod_reg[rsnp_pkg::DOT_W-1:0])
                           << rsnp_pkg::HALF_W);
                    STEP_AHH: ac_reg <= ac_reg
                        + (rsnp_pkg::WIDE_W'(prod_reg[rsnp_pkg::DOT_W-1:0])
                           << (2 * rsnp_pkg::HALF_W));
                    default: ;
                endcase
            end
            rsnp_pkg::ST_CLASSIFY:
            begin
                c_reg <= rsnp_pkg::MAG_W'(oo_reg - r2_reg);
                hm_reg <= h_reg[rsnp_pkg::DOT_W-1] ? rsnp_pkg::MAG_W'(-h_reg)
                                                   : rsnp_pkg::MAG_W'(h_reg);
                step_reg <= STEP_HLL;
            end
            rsnp_pkg::ST_DISC:
            begin
                rad_reg <= bb_reg - ac_reg;
                rem_reg <= '0;
                root_reg <= '0;
                cnt_reg <= CNT_W'(SQRT_STEPS - 1);
            end
            rsnp_pkg::ST_SQRT:
            begin
                rad_reg <= {rad_reg[rsnp_pkg::WIDE_W-3:0], 2'b00};
                rem_reg <= take_bit ? (rem_shift - trial) : rem_shift;
                root_reg <= {root_reg[rsnp_pkg::ROOT_W-2:0], take_bit};
                cnt_reg <= cnt_reg - 1'b1;
            end
            rsnp_pkg::ST_ROOT:
            begin
                // Near root unless it lies behind the origin.
                num_reg <= near_num[rsnp_pkg::NUM_W-1] ? (neg_h + s_ext) : near_num;
                hit_reg <= 1'b1;
            end
            rsnp_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_found_reg <= best_valid_reg;
                    out_index_reg <= best_valid_reg ? rsnp_pkg::INDEX_W'(best_pos_reg) : '0;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_index = out_index_reg;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Stream test of the nearest ray-sphere pick block.
// ============================================================================
// Pick queries of sphere centres go in on the s_ channel, and each query's
// found flag and nearest index are checked against an exact integer
// prediction of the ray-sphere test. The ray and radius registers are
// reprogrammed between phases over APB while the block is idle.
// ============================================================================
module tb;

    localparam int MAX_CENTRES = 1024;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic signed [23:0] cz;
        logic signed [23:0] cy;
        logic signed [23:0] cx;
        logic               last;
    } centre_t;

    typedef struct packed {
        logic       found;
        logic [9:0] index;
    } pick_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ray_sphere_nearest_pick u_top
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Predictor copy of the configuration registers.
    logic        [22:0] radius_q;
    logic signed [23:0] org_q[3];
    logic signed [23:0] dir_q[3];

    // Running query state of the predictor.
    logic signed [55:0] best_num;
    logic               best_hit;
    logic [9:0]         best_pos;
    int                 query_pos;

    centre_t pending_centres[$];
    pick_t   expected_picks[$];
    int      error_count = 0;
    int      centres_sent = 0;
    int      picks_seen = 0;
    int      hits_seen = 0;
    int      quiet_cycles = 0;
    bit      idle_enable = 1'b1;
    bit      hold_sender = 1'b0;
    bit      in_fire = 1'b0;
    int      send_gap = 0;
    int      take_gap = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Floor square root of a non-negative 128-bit value, bit by bit.
    function automatic logic [63:0] floor_root(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  cand;
        r = '0;
        for (int b = 62; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= v)
                r = cand;
        end
        return r;
    endfunction

    // Chosen root numerator of one centre, or no hit.
    function automatic bit sphere_root(input centre_t c, output logic signed [55:0] num);
        logic signed [127:0] ox, oy, oz, dx, dy, dz, r2, oo, a, h, cc, disc;
        logic signed [127:0] s, n;
        ox = 128'(org_q[0]) - 128'(c.cx);
        oy = 128'(org_q[1]) - 128'(c.cy);
        oz = 128'(org_q[2]) - 128'(c.cz);
        dx = 128'(dir_q[0]);
        dy = 128'(dir_q[1]);
        dz = 128'(dir_q[2]);
        r2 = $signed({105'd0, radius_q}) * $signed({105'd0, radius_q});
        oo = ox * ox + oy * oy + oz * oz;
        num = '0;
        if (oo <= r2)
            return 1'b0;
        a = dx * dx + dy * dy + dz * dz;
        if (a == 0)
            return 1'b0;
        h = ox * dx + oy * dy + oz * dz;
        cc = oo - r2;
        disc = h * h - a * cc;
        if (disc < 0)
            return 1'b0;
        s = $signed({64'd0, floor_root(disc)});
        n = -h - s;
        if (n < 0)
            n = -h + s;
        num = n[55:0];
        return 1'b1;
    endfunction

    // Advance the predictor by one accepted centre.
    function automatic void predict_centre(input centre_t c);
        logic signed [55:0] num;
        pick_t p;
        if (query_pos < MAX_CENTRES)
        begin
            if (sphere_root(c, num) && (!best_hit || num < best_num))
            begin
                best_hit = 1'b1;
                best_num = num;
                best_pos = query_pos[9:0];
            end
            query_pos++;
        end
        if (c.last)
        begin
            p.found = best_hit;
            p.index = best_hit ? best_pos : 10'd0;
            expected_picks.push_back(p);
            best_hit = 1'b0;
            best_num = '0;
            best_pos = '0;
            query_pos = 0;
        end
    endfunction

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rsnp_pkg::REG_RADIUS:   radius_q = value[22:0];
            rsnp_pkg::REG_ORIGIN_X: org_q[0] = value[23:0];
            rsnp_pkg::REG_ORIGIN_Y: org_q[1] = value[23:0];
            rsnp_pkg::REG_ORIGIN_Z: org_q[2] = value[23:0];
            rsnp_pkg::REG_DIR_X:    dir_q[0] = value[23:0];
            rsnp_pkg::REG_DIR_Y:    dir_q[1] = value[23:0];
            rsnp_pkg::REG_DIR_Z:    dir_q[2] = value[23:0];
            default: ;
        endcase
    endtask

    task automatic set_ray(input int r, input int ox, input int oy, input int oz,
                           input int dx, input int dy, input int dz);
        write_register(rsnp_pkg::REG_RADIUS, r);
        write_register(rsnp_pkg::REG_ORIGIN_X, ox);
        write_register(rsnp_pkg::REG_ORIGIN_Y, oy);
        write_register(rsnp_pkg::REG_ORIGIN_Z, oz);
        write_register(rsnp_pkg::REG_DIR_X, dx);
        write_register(rsnp_pkg::REG_DIR_Y, dy);
        write_register(rsnp_pkg::REG_DIR_Z, dz);
    endtask

    // Wait until every queued centre is taken and every pick has come back,
    // then let the back drain a centre that gives no result.
    task automatic drain_all();
        wait (pending_centres.size() == 0 && !s_tvalid);
        wait (expected_picks.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic centre_t make_centre(input int x, input int y, input int z, input bit l);
        centre_t c;
        c.cx = 24'(x);
        c.cy = 24'(y);
        c.cz = 24'(z);
        c.last = l;
        return c;
    endfunction

    // Random centre: mostly near the ray so that hits are common, sometimes anywhere.
    function automatic centre_t random_centre(input bit l);
        centre_t c;
        if ($urandom_range(0, 3) == 0)
        begin
            c.cx = 24'($urandom);
            c.cy = 24'($urandom);
            c.cz = 24'($urandom);
        end
        else
        begin
            c.cx = org_q[0] + $signed(24'($urandom_range(0, 16383)) - 24'sd8192);
            c.cy = org_q[1] + $signed(24'($urandom_range(0, 16383)) - 24'sd8192);
            c.cz = org_q[2] + $signed(24'($urandom_range(0, 131071)) - 24'sd65536);
        end
        c.last = l;
        return c;
    endfunction

    task automatic queue_random_queries(input int n_centres);
        int left;
        int len;
        left = n_centres;
        while (left > 0)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
                pending_centres.push_back(random_centre(i == len - 1));
            left -= len;
        end
    endtask

    // Driver: one request per accepted handshake, inputs change at negedge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (!hold_sender && pending_centres.size() > 0)
                begin
                    centre_t c;
                    c = pending_centres.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {c.cz, c.cy, c.cx};
                    s_tlast <= c.last;
                    if (idle_enable && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 7);
                end
                else
                    s_tvalid <= 1'b0;
            end
            if (take_gap > 0)
            begin
                take_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_enable && $urandom_range(0, 5) == 0)
                    take_gap = $urandom_range(1, 7);
            end
        end
    end

    // The monitor predicts each centre at the edge that accepts it, so a
    // pick is always preceded by its expectation.
    pick_t seen_picks[$];

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                predict_centre({s_tdata, s_tlast});
                centres_sent++;
            end
            if (m_tvalid && m_tready)
            begin
                pick_t p;
                p.found = m_tuser;
                p.index = m_tdata[9:0];
                seen_picks.push_back(p);
                picks_seen++;
                if (m_tuser)
                    hits_seen++;
                if (m_tdata[15:10] != 0)
                    report_mismatch("m_tdata fill", m_tdata[15:10], 0);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            // Compare everything whose expectation already exists.
            while (seen_picks.size() > 0 && expected_picks.size() > 0)
            begin
                pick_t got;
                pick_t want;
                got = seen_picks.pop_front();
                want = expected_picks.pop_front();
                if (got.found != want.found)
                    report_mismatch("found", got.found, want.found);
                if (got.index != want.index)
                    report_mismatch("nearest_index", got.index, want.index);
            end
            // A pick can only arrive after its last centre was predicted.
            if (seen_picks.size() > 0)
            begin
                report_mismatch("unexpected pick count", seen_picks.size(), 0);
                seen_picks.delete();
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        radius_q = 23'd4506;
        org_q[0] = '0; org_q[1] = '0; org_q[2] = '0;
        dir_q[0] = '0; dir_q[1] = '0; dir_q[2] = 24'sd4096;
        best_num = '0;
        best_hit = 1'b0;
        best_pos = '0;
        query_pos = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: default ray down +z through spheres along the axis.
        pending_centres.push_back(make_centre(0, 0, 40960, 0));
        pending_centres.push_back(make_centre(0, 0, 20480, 0));
        pending_centres.push_back(make_centre(0, 0, 20480, 1));      // tie keeps first
        pending_centres.push_back(make_centre(0, 0, 0, 1));          // origin inside
        pending_centres.push_back(make_centre(0, 0, -20480, 1));     // behind: far root
        pending_centres.push_back(make_centre(8388607, -8388608, 8388607, 0));
        pending_centres.push_back(make_centre(-8388608, 8388607, -8388608, 1));
        pending_centres.push_back(make_centre(40960, 0, 8192, 1));   // miss
        pending_centres.push_back(make_centre(4506, 0, 8192, 1));    // grazing
        drain_all();

        // Zero direction never hits.
        set_ray(4506, 0, 0, 0, 0, 0, 0);
        pending_centres.push_back(make_centre(0, 0, 8192, 0));
        pending_centres.push_back(make_centre(0, 0, -8192, 1));
        drain_all();

        // Extreme registers: full radius and extreme origin and direction.
        set_ray(8388607, -8388608, 8388607, -8388608, 8388607, -8388608, 8388607);
        pending_centres.push_back(make_centre(8388607, -8388608, 8388607, 0));
        pending_centres.push_back(make_centre(-8388608, 8388607, -8388608, 1));
        drain_all();
        set_ray(0, 8388607, -8388608, 8388607, -8388608, 8388607, -8388608);
        pending_centres.push_back(make_centre(0, 0, 0, 0));
        pending_centres.push_back(make_centre(-8388608, 8388607, -8388608, 1));
        drain_all();

        // A query with more centres than the position counter accepts.
        set_ray(4506, 0, 0, 0, 0, 0, 4096);
        for (int i = 0; i < MAX_CENTRES + 4; i++)
            pending_centres.push_back(i == MAX_CENTRES + 1 ? make_centre(0, 0, 8192, 0)
                : make_centre(i < 3 ? 0 : 409600, 0, 81920 - i, i == MAX_CENTRES + 3));
        drain_all();

        // Random phases with a fresh ray each time.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_ray($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16384),
                    $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                    $urandom_range(0, 1) ? $urandom : $urandom_range(1024, 8192));
            queue_random_queries(50);
            if (ph == 2)
            begin
                // Hold the sender until every pick has returned.
                wait (pending_centres.size() < 25);
                hold_sender = 1'b1;
                wait (expected_picks.size() == 0 && !s_tvalid);
                repeat (SETTLE_CYCLES) @(posedge clk);
                hold_sender = 1'b0;
            end
            drain_all();
        end

        // Final stretch without idling.
        idle_enable = 1'b0;
        queue_random_queries(100);
        drain_all();

        $display("sent %0d centres over directed and random rays; %0d picks, %0d hits",
                 centres_sent, picks_seen, hits_seen);
        if (error_count == 0 && expected_picks.size() == 0 && seen_picks.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
